// ===== sv/gdd_pkg.sv =====
package gdd_pkg;

   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 14;
   localparam int STATUS_W = 2;
   localparam int DIFF_W   = 22;

   localparam int MAX_YEAR_DEF = 9999;

   localparam logic [DIFF_W-1:0] DIFF_MAX = {DIFF_W{1'b1}};

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FIRST_BAD  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SECOND_BAD = 2'd2;

   // x / 100 for any 14-bit x: 5243 / 2^19 is close enough below 16384
   localparam int          RECIP_100   = 5243;
   localparam int          RECIP_SHIFT = 19;
   localparam int          PROD_W      = YEAR_W + 13;
   localparam int          QUOT_W      = 8;

   typedef struct packed {
      logic [DAY_W-1:0]   first_day;
      logic [MONTH_W-1:0] first_month;
      logic [YEAR_W-1:0]  first_year;
      logic [DAY_W-1:0]   second_day;
      logic [MONTH_W-1:0] second_month;
      logic [YEAR_W-1:0]  second_year;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DIFF_W-1:0]   day_difference;
   } rsp_type;

   function automatic logic [QUOT_W-1:0] div100(input logic [YEAR_W-1:0] x);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(x) * PROD_W'(RECIP_100);
      return prod[RECIP_SHIFT +: QUOT_W];
   endfunction

   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      logic [QUOT_W-1:0] q;
      logic [YEAR_W-1:0] r;
      q = div100(y);
      r = y - YEAR_W'(q) * YEAR_W'(100);
      return (y[1:0] == 2'd0) && ((r != '0) || (q[1:0] == 2'd0));
   endfunction

   // Days before the first of the month in a common year.
   function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
      logic [8:0] v;
      case (m)
         4'd1:    v = 9'd0;
         4'd2:    v = 9'd31;
         4'd3:    v = 9'd59;
         4'd4:    v = 9'd90;
         4'd5:    v = 9'd120;
         4'd6:    v = 9'd151;
         4'd7:    v = 9'd181;
         4'd8:    v = 9'd212;
         4'd9:    v = 9'd243;
         4'd10:   v = 9'd273;
         4'd11:   v = 9'd304;
         4'd12:   v = 9'd334;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic               leap);
      logic [DAY_W-1:0] v;
      case (m)
         4'd2:    v = leap ? 5'd29 : 5'd28;
         4'd4,
         4'd6,
         4'd9,
         4'd11:   v = 5'd30;
         default: v = 5'd31;
      endcase
      return v;
   endfunction

endpackage

// ===== sv/gdd_date.sv =====
module gdd_date #(
   parameter int MAX_YEAR = gdd_pkg::MAX_YEAR_DEF,
   parameter int SERIAL_W = 22
) (
   input  logic [gdd_pkg::DAY_W-1:0]   day,
   input  logic [gdd_pkg::MONTH_W-1:0] month,
   input  logic [gdd_pkg::YEAR_W-1:0]  year,
   output logic                        date_ok,
   output logic [SERIAL_W-1:0]         serial
);

   logic                        leap;
   logic [gdd_pkg::YEAR_W-1:0]  prev_year;
   logic [gdd_pkg::YEAR_W-1:0]  prev_quarter;
   logic [gdd_pkg::DAY_W-1:0]   day_limit;

   assign leap         = gdd_pkg::is_leap(year);
   assign prev_year    = year - gdd_pkg::YEAR_W'(1);
   assign prev_quarter = gdd_pkg::YEAR_W'(prev_year[gdd_pkg::YEAR_W-1:2]);
   assign day_limit    = gdd_pkg::month_len(month, leap);

   always_comb begin
      date_ok = (year != '0)
             && (year <= gdd_pkg::YEAR_W'(MAX_YEAR))
             && (month inside {[4'd1:4'd12]})
             && (day != '0)
             && (day <= day_limit);
   end

   // Whole days before Jan 1 of this year, then month offset, leap day, day.
   always_comb begin
      serial = SERIAL_W'(prev_year) * SERIAL_W'(365)
             + SERIAL_W'(prev_quarter)
             - SERIAL_W'(gdd_pkg::div100(prev_year))
             + SERIAL_W'(gdd_pkg::div100(prev_quarter))
             + SERIAL_W'(gdd_pkg::month_start(month))
             + SERIAL_W'(leap && (month > 4'd2))
             + SERIAL_W'(day);
   end

endmodule

// ===== sv/gregorian_date_difference.sv =====
// Gregorian date difference.
// Input channel: raise start with a date pair on req_data; the word is taken
// at the clock edge where start is high and busy is low. busy stays low, so
// a new pair may be offered in every cycle.
// Result channel: rsp_valid is high for one cycle with rsp_data holding the
// status (ok, first date invalid, second date invalid) and the absolute day
// difference, which is zero for an invalid pair and saturates at the 22-bit
// maximum. Results come out in the order the pairs went in.
// A taken pair goes into the input register, its result into the result
// register; throughput is one pair per cycle. The path between the
// input register and the result register holds the two date checks, the
// closed-form day numbers (constant multiplies by 365 and by a reciprocal of
// 100) and one subtract with saturation.
// Reset clears both valid flags; nothing in flight survives it. The receiver
// cannot stall: rsp_valid marks each result word for exactly one cycle.
module gregorian_date_difference #(
   parameter int MAX_YEAR = gdd_pkg::MAX_YEAR_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  gdd_pkg::req_type req_data,
   output logic             rsp_valid,
   output gdd_pkg::rsp_type rsp_data
);

   localparam int SERIAL_W = $clog2(MAX_YEAR * 366 + 32);
   localparam int EXT_W    = SERIAL_W + gdd_pkg::DIFF_W;

   logic             req_valid_ff;
   gdd_pkg::req_type req_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   gdd_pkg::rsp_type rsp_ff;
   gdd_pkg::rsp_type rsp_in;

   logic                first_ok;
   logic                second_ok;
   logic [SERIAL_W-1:0] first_serial;
   logic [SERIAL_W-1:0] second_serial;
   logic [SERIAL_W-1:0] diff;
   logic [EXT_W-1:0]    diff_ext;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
   end

   gdd_date #(
      .MAX_YEAR (MAX_YEAR),
      .SERIAL_W (SERIAL_W)
   ) u_first (
      .day     (req_ff.first_day),
      .month   (req_ff.first_month),
      .year    (req_ff.first_year),
      .date_ok (first_ok),
      .serial  (first_serial)
   );

   gdd_date #(
      .MAX_YEAR (MAX_YEAR),
      .SERIAL_W (SERIAL_W)
   ) u_second (
      .day     (req_ff.second_day),
      .month   (req_ff.second_month),
      .year    (req_ff.second_year),
      .date_ok (second_ok),
      .serial  (second_serial)
   );

   always_comb begin
      diff     = (first_serial >= second_serial) ? (first_serial - second_serial)
                                                 : (second_serial - first_serial);
      diff_ext = EXT_W'(diff);
      rsp_in   = '0;
      if (!first_ok) begin
         rsp_in.status = gdd_pkg::STATUS_FIRST_BAD;
      end else if (!second_ok) begin
         rsp_in.status = gdd_pkg::STATUS_SECOND_BAD;
      end else begin
         rsp_in.status = gdd_pkg::STATUS_OK;
         // clamp only reachable with a raised year limit
         if (diff_ext > EXT_W'(gdd_pkg::DIFF_MAX)) begin
            rsp_in.day_difference = gdd_pkg::DIFF_MAX;
         end else begin
            rsp_in.day_difference = diff_ext[gdd_pkg::DIFF_W-1:0];
         end
      end
      rsp_valid_in = req_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/gdd_checker.sv =====
module gdd_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input gdd_pkg::req_type req_data,
   input logic             rsp_valid,
   input gdd_pkg::rsp_type rsp_data
);

   // every accepted word yields a result after the input and result registers
   a_accept_to_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("accepted word produced no result");

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without an accepted word");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == gdd_pkg::STATUS_OK
                  || rsp_data.status == gdd_pkg::STATUS_FIRST_BAD
                  || rsp_data.status == gdd_pkg::STATUS_SECOND_BAD))
      else $error("illegal status code");

   a_bad_zero_diff: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != gdd_pkg::STATUS_OK)
         |-> (rsp_data.day_difference == '0))
      else $error("invalid pair with nonzero difference");

   a_same_date_zero: assert property (@(posedge clock) disable iff (reset)
      (start && !busy
         && req_data.first_day == req_data.second_day
         && req_data.first_month == req_data.second_month
         && req_data.first_year == req_data.second_year)
         |-> ##2 (rsp_data.day_difference == '0))
      else $error("identical dates with nonzero difference");

endmodule

bind gregorian_date_difference gdd_checker u_gdd_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

// ===== dv/tb_gregorian_date_difference.sv =====
`timescale 1ns / 1ps

module tb_gregorian_date_difference;

   localparam int MAX_YEAR   = gdd_pkg::MAX_YEAR_DEF;
   localparam int STALL_CAP  = 1000;
   localparam int REPORT_CAP = 10;
   localparam int REQ_W      = $bits(gdd_pkg::req_type);

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   gdd_pkg::req_type req_data;
   logic             rsp_valid;
   gdd_pkg::rsp_type rsp_data;

   gdd_pkg::rsp_type expected_gaps[$];
   int               gap_errors  = 0;
   int               rsp_count   = 0;
   int               idle_cycles = 0;
   bit               gaps_on     = 1'b1;

   gregorian_date_difference #(
      .MAX_YEAR(MAX_YEAR)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit leap_year(input int y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
   endfunction

   function automatic int month_days(input int m, input int y);
      case (m)
         2:          return leap_year(y) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:    return 31;
      endcase
   endfunction

   function automatic bit date_valid(input int d, input int m, input int y);
      if (y < 1 || y > MAX_YEAR || m < 1 || m > 12 || d < 1)
         return 1'b0;
      return d <= month_days(m, y);
   endfunction

   // Day 1 is the first of January of year one.
   function automatic int day_number(input int d, input int m, input int y);
      int p;
      int n;
      p = y - 1;
      n = p * 365 + p / 4 - p / 100 + p / 400;
      for (int k = 1; k < m; k++)
         n += month_days(k, y);
      return n + d;
   endfunction

   function automatic gdd_pkg::rsp_type predict_gap(input gdd_pkg::req_type w);
      gdd_pkg::rsp_type r;
      int               a;
      int               b;
      int               gap;
      r.status         = gdd_pkg::STATUS_OK;
      r.day_difference = '0;
      if (!date_valid(w.first_day, w.first_month, w.first_year)) begin
         r.status = gdd_pkg::STATUS_FIRST_BAD;
      end else if (!date_valid(w.second_day, w.second_month, w.second_year)) begin
         r.status = gdd_pkg::STATUS_SECOND_BAD;
      end else begin
         a   = day_number(w.first_day, w.first_month, w.first_year);
         b   = day_number(w.second_day, w.second_month, w.second_year);
         gap = (a >= b) ? a - b : b - a;
         r.day_difference = (gap > int'(gdd_pkg::DIFF_MAX)) ? gdd_pkg::DIFF_MAX
                                                            : gdd_pkg::DIFF_W'(gap);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic gdd_pkg::req_type pair_of(input int d1, input int m1, input int y1,
                                                input int d2, input int m2, input int y2);
      gdd_pkg::req_type w;
      w.first_day    = gdd_pkg::DAY_W'(d1);
      w.first_month  = gdd_pkg::MONTH_W'(m1);
      w.first_year   = gdd_pkg::YEAR_W'(y1);
      w.second_day   = gdd_pkg::DAY_W'(d2);
      w.second_month = gdd_pkg::MONTH_W'(m2);
      w.second_year  = gdd_pkg::YEAR_W'(y2);
      return w;
   endfunction

   function automatic void pick_date(output logic [gdd_pkg::DAY_W-1:0]   d,
                                     output logic [gdd_pkg::MONTH_W-1:0] m,
                                     output logic [gdd_pkg::YEAR_W-1:0]  y);
      int yy;
      int mm;
      int len;
      case ($urandom_range(0, 7))
         0:       yy = $urandom_range(1, 12);
         1:       yy = $urandom_range(MAX_YEAR - 12, MAX_YEAR);
         2:       yy = $urandom_range(1, MAX_YEAR / 100) * 100;
         3:       yy = $urandom_range(1, MAX_YEAR / 4) * 4;
         default: yy = $urandom_range(1, MAX_YEAR);
      endcase
      mm  = $urandom_range(1, 12);
      len = month_days(mm, yy);
      d   = gdd_pkg::DAY_W'(($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len));
      m   = gdd_pkg::MONTH_W'(mm);
      y   = gdd_pkg::YEAR_W'(yy);
   endfunction

   // Push one field of a valid date out of range.
   function automatic void break_date(inout logic [gdd_pkg::DAY_W-1:0]   d,
                                      inout logic [gdd_pkg::MONTH_W-1:0] m,
                                      inout logic [gdd_pkg::YEAR_W-1:0]  y);
      int len;
      len = month_days(m, y);
      case ($urandom_range(0, 3))
         0: d = (len < 31) ? gdd_pkg::DAY_W'($urandom_range(len + 1, 31)) : '0;
         1: m = ($urandom_range(0, 1) == 0) ? '0
                                            : gdd_pkg::MONTH_W'($urandom_range(13, 15));
         2: y = '0;
         default: y = gdd_pkg::YEAR_W'($urandom_range(MAX_YEAR + 1,
                                                      (1 << gdd_pkg::YEAR_W) - 1));
      endcase
   endfunction

   function automatic gdd_pkg::req_type random_valid_pair();
      gdd_pkg::req_type w;
      pick_date(w.first_day, w.first_month, w.first_year);
      pick_date(w.second_day, w.second_month, w.second_year);
      return w;
   endfunction

   function automatic gdd_pkg::req_type random_bad_pair();
      gdd_pkg::req_type w;
      w = random_valid_pair();
      case ($urandom_range(0, 3))
         0: w = gdd_pkg::req_type'(REQ_W'({$urandom, $urandom}));
         1: break_date(w.first_day, w.first_month, w.first_year);
         2: break_date(w.second_day, w.second_month, w.second_year);
         default: begin
            break_date(w.first_day, w.first_month, w.first_year);
            break_date(w.second_day, w.second_month, w.second_year);
         end
      endcase
      return w;
   endfunction

   // Hold the word until it is taken, then maybe go quiet for a burst.
   task automatic send_pair(input gdd_pkg::req_type w);
      req_data <= w;
      start    <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      expected_gaps.push_back(predict_gap(w));
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (expected_gaps.size() != 0)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed();
      send_pair(pair_of(0, 0, 0, 0, 0, 0));
      send_pair(pair_of(31, 15, 16383, 31, 15, 16383));
      send_pair(pair_of(1, 1, 1, 1, 1, 1));
      send_pair(pair_of(1, 1, 1, 31, 12, MAX_YEAR));
      send_pair(pair_of(31, 12, MAX_YEAR, 1, 1, 1));
      send_pair(pair_of(15, 6, 2020, 15, 6, 0));
      send_pair(pair_of(15, 6, 2020, 15, 0, 2020));
      send_pair(pair_of(15, 6, 2020, 0, 6, 2020));
      send_pair(pair_of(1, 13, 2020, 1, 1, 2020));
      send_pair(pair_of(1, 15, 2020, 0, 14, 0));
      send_pair(pair_of(1, 1, MAX_YEAR + 1, 1, 1, 1));
      send_pair(pair_of(1, 1, 1, 1, 1, 16383));
      send_pair(pair_of(29, 2, 2000, 1, 3, 1900));
      send_pair(pair_of(1, 3, 1900, 29, 2, 1900));
      send_pair(pair_of(29, 2, 2024, 29, 2, 2023));
      send_pair(pair_of(29, 2, 2100, 1, 1, 2100));
      send_pair(pair_of(31, 4, 2004, 1, 4, 2004));
      send_pair(pair_of(31, 12, 1999, 1, 1, 2000));
      send_pair(pair_of(1, 3, 2000, 28, 2, 2000));
      send_pair(pair_of(31, 1, 2023, 1, 12, 2023));
      send_pair(pair_of(29, 2, 400, 31, 12, MAX_YEAR));
      send_pair(pair_of(30, 11, 1582, 32, 10, 1582));
   endtask

   task automatic test_valid_pairs(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 150 == 0)
            gaps_on = ($urandom_range(0, 3) != 0);
         send_pair((i % 8 == 7) ? random_bad_pair() : random_valid_pair());
      end
      gaps_on = 1'b1;
   endtask

   task automatic test_malformed_pairs(input int count);
      for (int i = 0; i < count; i++)
         send_pair(random_bad_pair());
   endtask

   task automatic test_drain_pause();
      for (int i = 0; i < 20; i++)
         send_pair(random_valid_pair());
      wait_drained();
      for (int i = 0; i < 20; i++)
         send_pair(random_valid_pair());
   endtask

   task automatic test_back_to_back(input int count);
      gaps_on = 1'b0;
      for (int i = 0; i < count; i++)
         send_pair(($urandom_range(0, 3) == 0) ? random_bad_pair() : random_valid_pair());
   endtask

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_valid_pairs(1450);
      test_drain_pause();
      test_malformed_pairs(300);
      test_back_to_back(140);

      wait_drained();
      repeat (8) @(posedge clock);
      if (gap_errors == 0) begin
         $display("[gregorian_date_difference] OK");
      end else begin
         $display("[gregorian_date_difference] ERROR");
      end
      $finish;
   end

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin
      gdd_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         rsp_count++;
         if (expected_gaps.size() == 0) begin
            gap_errors++;
            if (gap_errors <= REPORT_CAP)
               $display("word %0d: unexpected result status %0d diff %0d",
                        rsp_count, rsp_data.status, rsp_data.day_difference);
         end else begin
            want = expected_gaps.pop_front();
            if (rsp_data.status !== want.status ||
                rsp_data.day_difference !== want.day_difference) begin
               gap_errors++;
               if (gap_errors <= REPORT_CAP)
                  $display("word %0d: expected status %0d diff %0d, got status %0d diff %0d",
                           rsp_count, want.status, want.day_difference,
                           rsp_data.status, rsp_data.day_difference);
            end
         end
      end
   end

   // Stop a hung run: count cycles with no word moving either way.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_CAP) begin
            $display("[gregorian_date_difference] ERROR");
            $finish;
         end
      end
   end

endmodule
